// ===== rtl/rvsc_pkg.sv =====
package rvsc_pkg;

   localparam int DMEM_BYTES_DEF = 1024;

   typedef enum logic [1:0] {
      CMD_EXECUTE    = 2'd0,
      CMD_WRITE_BYTE = 2'd1,
      CMD_READ_WORD  = 2'd2,
      CMD_READ_REG   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_RANGE   = 2'd2,
      ST_HALTED  = 2'd3
   } status_type;

   localparam logic [6:0] OP_R      = 7'b0110011;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;

   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

   // One data memory access, issued when the execute stage advances.
   typedef struct packed {
      logic        rd;
      logic        wr_word;
      logic        wr_byte;
      logic [31:0] addr;
      logic [31:0] wdata;
   } dmem_req_type;

   // Everything the execute stage decides for one request.
   typedef struct packed {
      logic [31:0]  pc_next;
      logic         halt_next;
      logic         wen;
      logic [4:0]   widx;
      logic [31:0]  wval;
      logic [31:0]  readv;
      status_type   status;
      logic         mem_to_wval;
      logic         mem_to_readv;
      dmem_req_type mem;
   } exec_type;

endpackage

// ===== rtl/rvsc_regfile.sv =====
module rvsc_regfile
   import rvsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] rd_data_a_ff;
   logic [31:0] rd_data_b_ff;
   logic [31:0] stored_a;
   logic [31:0] stored_b;

   // Entries never written read as zero, which also keeps x0 at zero.
   assign stored_a = valid_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
   assign stored_b = valid_ff[rd_addr_b] ? mem[rd_addr_b] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Write-first: a write in the same cycle is seen by the read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : stored_a;
         rd_data_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : stored_b;
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/rvsc_dmem.sv =====
module rvsc_dmem
   import rvsc_pkg::*;
#(
   parameter int DMEM_BYTES = DMEM_BYTES_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  dmem_req_type req,
   output logic         busy,
   output logic [31:0]  rd_word
);

   localparam int AW   = $clog2(DMEM_BYTES);
   localparam int RW   = AW - 2;
   localparam int ROWS = (DMEM_BYTES + 3) / 4;

   logic          clearing_ff;
   logic [RW-1:0] clr_row_ff;
   logic          rd_valid_ff;
   logic [1:0]    off_ff;
   logic [1:0]    off;
   logic [RW-1:0] base;
   logic [7:0]    bank_q [4];
   logic [31:0]   word;

   assign off  = req.addr[1:0];
   assign base = req.addr[AW-1:2];
   assign busy = clearing_ff;

   // Zero the memory one row of four bytes per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clearing_ff) begin
         if (clr_row_ff == RW'(ROWS - 1)) begin
            clearing_ff <= 1'b0;
         end
         clr_row_ff <= clr_row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (advance) begin
         rd_valid_ff <= req.rd;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         off_ff <= off;
      end
   end

   // Byte a lives in bank a[1:0], row a >> 2, so any four consecutive bytes
   // fall into four different banks.
   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [7:0]    bank [ROWS];
      logic [RW-1:0] row;
      logic [1:0]    j;
      logic          we;
      logic [RW-1:0] wa;
      logic [7:0]    wd;
      logic [7:0]    q_ff;

      assign row = base + RW'(2'(k) < off);
      assign j   = 2'(k) - off;

      always_comb begin
         if (clearing_ff) begin
            we = 1'b1;
            wa = clr_row_ff;
            wd = '0;
         end else begin
            we = advance && (req.wr_word || (req.wr_byte && off == 2'(k)));
            wa = row;
            wd = req.wr_word ? req.wdata[{~j, 3'b000} +: 8] : req.wdata[7:0];
         end
      end

      always_ff @(posedge clock) begin
         if (we) begin
            bank[wa] <= wd;
         end
         if (advance && req.rd) begin
            q_ff <= bank[row];
         end
      end

      assign bank_q[k] = q_ff;
   end

   // Big-endian: the byte at the lowest address is the top byte.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         word[8*(3-i) +: 8] = bank_q[2'(off_ff + 2'(i))];
      end
   end

   assign rd_word = rd_valid_ff ? word : '0;

endmodule

// ===== rtl/rvsc_exec.sv =====
module rvsc_exec
   import rvsc_pkg::*;
#(
   parameter int DMEM_BYTES = DMEM_BYTES_DEF
)
(
   input  logic [1:0]  command,
   input  logic [31:0] instruction,
   input  logic [9:0]  byte_address,
   input  logic [7:0]  byte_value,
   input  logic [31:0] a_value,
   input  logic [31:0] b_value,
   input  logic [31:0] pc,
   input  logic        halted,
   output exec_type    result
);

   localparam logic [31:0] MemBytes = 32'(DMEM_BYTES);
   localparam logic [31:0] LastWord = 32'(DMEM_BYTES - 4);

   logic [6:0]  op;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_j;
   logic [31:0] imm_b;
   logic [31:0] addr_load;
   logic [31:0] addr_store;
   logic [31:0] byte_addr32;
   logic [31:0] pc_plus4;
   logic [31:0] res;
   logic        wr;
   logic        is_load;

   assign op    = instruction[6:0];
   assign rd    = instruction[11:7];
   assign f3    = instruction[14:12];
   assign f7    = instruction[31:25];
   assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                   instruction[20], instruction[30:21], 1'b0};
   assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};

   assign addr_load   = a_value + imm_i;
   assign addr_store  = a_value + imm_s;
   assign byte_addr32 = {22'b0, byte_address};
   assign pc_plus4    = pc + 32'd4;

   always_comb begin
      result           = '0;
      result.pc_next   = pc;
      result.halt_next = halted;
      result.status    = ST_OK;
      res              = '0;
      wr               = 1'b0;
      is_load          = 1'b0;
      case (cmd_type'(command))
         CMD_WRITE_BYTE: begin
            result.mem.addr = byte_addr32;
            if (byte_addr32 < MemBytes) begin
               result.mem.wr_byte = 1'b1;
               result.mem.wdata   = {24'b0, byte_value};
            end else begin
               result.status = ST_RANGE;
            end
         end
         CMD_READ_WORD: begin
            result.mem.addr     = byte_addr32;
            result.mem_to_readv = 1'b1;
            if (byte_addr32 <= LastWord) begin
               result.mem.rd = 1'b1;
            end else begin
               result.status = ST_RANGE;
            end
         end
         CMD_READ_REG: begin
            result.readv = a_value;
         end
         CMD_EXECUTE: begin
            if (halted) begin
               result.status = ST_HALTED;
            end else if (instruction == HALT_WORD) begin
               result.halt_next = 1'b1;
            end else begin
               result.pc_next = pc_plus4;
               case (op)
                  OP_R: begin
                     if ((f3 inside {F3_ADD, F3_XOR, F3_OR, F3_AND}) &&
                         (f7 == F7_BASE || (f7 == F7_ALT && f3 == F3_ADD))) begin
                        wr = 1'b1;
                        case (f3)
                           F3_ADD:  res = (f7 == F7_ALT) ? a_value - b_value
                                                         : a_value + b_value;
                           F3_XOR:  res = a_value ^ b_value;
                           F3_OR:   res = a_value | b_value;
                           F3_AND:  res = a_value & b_value;
                           default: res = '0;
                        endcase
                     end else begin
                        result.status = ST_UNKNOWN;
                     end
                  end
                  OP_IMM: begin
                     if (f3 inside {F3_ADD, F3_XOR, F3_OR, F3_AND}) begin
                        wr = 1'b1;
                        case (f3)
                           F3_ADD:  res = addr_load;
                           F3_XOR:  res = a_value ^ imm_i;
                           F3_OR:   res = a_value | imm_i;
                           F3_AND:  res = a_value & imm_i;
                           default: res = '0;
                        endcase
                     end else begin
                        result.status = ST_UNKNOWN;
                     end
                  end
                  OP_LOAD: begin
                     if (f3 == F3_WORD) begin
                        wr              = 1'b1;
                        is_load         = 1'b1;
                        result.mem.addr = addr_load;
                        if (addr_load <= LastWord) begin
                           result.mem.rd = 1'b1;
                        end else begin
                           result.status = ST_RANGE;
                        end
                     end else begin
                        result.status = ST_UNKNOWN;
                     end
                  end
                  OP_STORE: begin
                     if (f3 == F3_WORD) begin
                        result.mem.addr  = addr_store;
                        result.mem.wdata = b_value;
                        if (addr_store <= LastWord) begin
                           result.mem.wr_word = 1'b1;
                        end else begin
                           result.status = ST_RANGE;
                        end
                     end else begin
                        result.status = ST_UNKNOWN;
                     end
                  end
                  OP_JAL: begin
                     wr             = 1'b1;
                     res            = pc_plus4;
                     result.pc_next = pc + imm_j;
                  end
                  OP_BRANCH: begin
                     if (f3 == F3_BEQ || f3 == F3_BNE) begin
                        if ((f3 == F3_BEQ) == (a_value == b_value)) begin
                           result.pc_next = pc + imm_b;
                        end
                     end else begin
                        result.status = ST_UNKNOWN;
                     end
                  end
                  default: begin
                     result.status = ST_UNKNOWN;
                  end
               endcase
               if (wr && rd != 5'd0) begin
                  result.wen         = 1'b1;
                  result.widx        = rd;
                  result.wval        = res;
                  result.mem_to_wval = is_load;
               end
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

endmodule

// ===== rtl/rv32i_subset_single_cycle_core.sv =====
// Core for a subset of RV32I (ADD, SUB, XOR, OR, AND, ADDI, XORI, ORI, ANDI,
// LW, SW, JAL, BEQ, BNE) driven one request at a time: each execute request
// carries the instruction word fetched at the PC that the previous response
// reported, and the other commands preload a data byte, read a big-endian
// data word, or read a register. Every request gets exactly one response.
// The block takes one request per cycle when the response side keeps up;
// each request passes through the execute stage into the response register. The
// register file is read as the request is accepted, the execute stage then
// decodes, computes and issues the data memory access, and the memory's own
// read register feeds the response outputs, so a load passes through the same
// stages as any other request.
// Results of the request held in the response register are forwarded into
// the execute stage, so back-to-back dependent instructions need no stall.
// After reset the data memory is zeroed one four-byte row per cycle and
// req_ready stays low during that pass. The halt word 0xFFFFFFFF freezes
// execution until reset, while the other commands keep working.
module rv32i_subset_single_cycle_core
   import rvsc_pkg::*;
#(
   parameter int DMEM_BYTES = DMEM_BYTES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_instruction,
   input  logic [9:0]  req_byte_address,
   input  logic [7:0]  req_byte_value,
   input  logic [4:0]  req_reg_select,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_written_index,
   output logic [31:0] rsp_written_value,
   output logic [31:0] rsp_read_value,
   output logic [1:0]  rsp_status
);

   // Handshake and stage movement.
   logic accept;
   logic s1_adv;
   logic rsp_take;
   logic dmem_busy;

   // Execute stage: the accepted request and its register operands.
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [1:0]  s1_command_ff;
   logic [31:0] s1_instruction_ff;
   logic [9:0]  s1_byte_address_ff;
   logic [7:0]  s1_byte_value_ff;
   logic [4:0]  s1_a_idx_ff;
   logic [4:0]  s1_b_idx_ff;
   logic [4:0]  rd_idx_a;
   logic [31:0] rf_a;
   logic [31:0] rf_b;
   logic [31:0] a_value;
   logic [31:0] b_value;

   // Architectural PC and halt flag, updated as a request leaves execute.
   logic [31:0] pc_ff;
   logic        halt_ff;

   // Response stage.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] s2_next_pc_ff;
   logic        s2_halted_ff;
   logic        s2_wen_ff;
   logic [4:0]  s2_widx_ff;
   logic [31:0] s2_wval_ff;
   logic [31:0] s2_readv_ff;
   status_type  s2_status_ff;
   logic        s2_mem_to_wval_ff;
   logic        s2_mem_to_readv_ff;
   logic [31:0] dmem_word;

   exec_type ex;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign req_ready = !dmem_busy && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);

   // A register read request uses the first read port.
   assign rd_idx_a = (cmd_type'(req_command) == CMD_READ_REG) ? req_reg_select
                                                              : req_instruction[19:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            pc_ff   <= ex.pc_next;
            halt_ff <= ex.halt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_command_ff      <= req_command;
         s1_instruction_ff  <= req_instruction;
         s1_byte_address_ff <= req_byte_address;
         s1_byte_value_ff   <= req_byte_value;
         s1_a_idx_ff        <= rd_idx_a;
         s1_b_idx_ff        <= req_instruction[24:20];
      end
   end

   // The register file is written as the response is taken. Until then the
   // pending write sits in the response stage and is forwarded from there.
   rvsc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_idx_a),
      .rd_addr_b (req_instruction[24:20]),
      .wr_en     (rsp_take && s2_wen_ff),
      .wr_addr   (s2_widx_ff),
      .wr_data   (rsp_written_value),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   assign a_value = (rsp_valid_ff && s2_wen_ff && s2_widx_ff == s1_a_idx_ff)
                    ? rsp_written_value : rf_a;
   assign b_value = (rsp_valid_ff && s2_wen_ff && s2_widx_ff == s1_b_idx_ff)
                    ? rsp_written_value : rf_b;

   rvsc_exec #(
      .DMEM_BYTES (DMEM_BYTES)
   ) u_exec (
      .command      (s1_command_ff),
      .instruction  (s1_instruction_ff),
      .byte_address (s1_byte_address_ff),
      .byte_value   (s1_byte_value_ff),
      .a_value      (a_value),
      .b_value      (b_value),
      .pc           (pc_ff),
      .halted       (halt_ff),
      .result       (ex)
   );

   // Stores and preloads land in memory as the request leaves execute, so a
   // later load, which reads memory when it leaves execute, always sees them.
   rvsc_dmem #(
      .DMEM_BYTES (DMEM_BYTES)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .req     (ex.mem),
      .busy    (dmem_busy),
      .rd_word (dmem_word)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_next_pc_ff      <= ex.pc_next;
         s2_halted_ff       <= ex.halt_next;
         s2_wen_ff          <= ex.wen;
         s2_widx_ff         <= ex.widx;
         s2_wval_ff         <= ex.wval;
         s2_readv_ff        <= ex.readv;
         s2_status_ff       <= ex.status;
         s2_mem_to_wval_ff  <= ex.mem_to_wval;
         s2_mem_to_readv_ff <= ex.mem_to_readv;
      end
   end

   // Memory data is zero for a read that was out of range.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = s2_next_pc_ff;
   assign rsp_halted        = s2_halted_ff;
   assign rsp_reg_written   = s2_wen_ff;
   assign rsp_written_index = s2_widx_ff;
   assign rsp_written_value = s2_mem_to_wval_ff ? dmem_word : s2_wval_ff;
   assign rsp_read_value    = s2_mem_to_readv_ff ? dmem_word : s2_readv_ff;
   assign rsp_status        = s2_status_ff;

endmodule

// ===== rtl/rvsc_checker.sv =====
module rvsc_checker
   import rvsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_next_pc,
   input logic        rsp_halted,
   input logic        rsp_reg_written,
   input logic [4:0]  rsp_written_index,
   input logic [31:0] rsp_written_value,
   input logic [1:0]  rsp_status
);

   // Once halted, every later response reports halted until reset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_halted) |=> (!rsp_valid || rsp_halted))
      else $error("halt flag dropped without reset");

   // An ignored execute request leaves the core halted and writes nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_HALTED) |-> (rsp_halted && !rsp_reg_written))
      else $error("ignored request changed state");

   // x0 is never reported as written, and no write means zero index and value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reg_written ? (rsp_written_index != 5'd0)
                     : (rsp_written_index == 5'd0 && rsp_written_value == '0)))
      else $error("inconsistent register write report");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_next_pc)
                                     && $stable(rsp_written_value)))
      else $error("stalled response changed");

endmodule

bind rv32i_subset_single_cycle_core rvsc_checker u_checker (.*);
